// ===== sv/bflm_pkg.sv =====
// Shared constants and types for the buffer frame LRU mapper.
`default_nettype none

package bflm_pkg;

  localparam int POOL_FRAMES = 16;
  localparam int IDX_W       = $clog2(POOL_FRAMES);
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(POOL_FRAMES + 1);
  localparam int PAGE_W      = 31;
  localparam int FRAME_W     = 4;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 40;

  localparam logic ACT_FETCH  = 1'b0;
  localparam logic ACT_CREATE = 1'b1;

  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(POOL_FRAMES - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(POOL_FRAMES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_PICK,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              fetch;
    logic              full;
    logic              found;
    logic              match_en;
    logic              pick_en;
    logic              apply_en;
  } cell_cmd_t;

  // Recency state of the selected frame, gathered from the cells.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              valid;
  } cell_bus_t;

  // Priority tokens passed from lower to higher frame index.
  typedef struct packed {
    logic hit;
    logic alloc;
  } chain_t;

  typedef struct packed {
    logic              sel;
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [PAGE_W-1:0] page;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/buffer_frame_lru_mapper_top.sv =====
// Top level: request sequencer, chain of frame cells and result register.
// m_tvalid rises after the request has passed the match, pick, apply and done steps;
// the done step holds until the output register is free, and no new input is taken before idle.
// The next input is taken while an earlier result still waits in the output register.
// Reset (rst, synchronous, active high) clears all valid bits, ranks and the used count.
`default_nettype none

module buffer_frame_lru_mapper_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [bflm_pkg::IN_W-1:0]   s_tdata,   // [30:0] page_id, [31] zero
  input  wire logic [0:0]                  s_tuser,   // [0] action
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [bflm_pkg::OUT_W-1:0]       m_tdata    // [3:0] frame, [4] hit, [5] evict_valid,
                                                      // [36:6] evict_page_id, [37] need_read,
                                                      // [38] need_zero, [39] zero
);

  bflm_pkg::state_t state;
  bflm_pkg::state_t state_next;

  logic                            act_q;
  logic [bflm_pkg::PAGE_W-1:0]     page_q;
  logic [bflm_pkg::CNT_W-1:0]      unused_count;
  logic                            found_q;
  logic                            full;
  logic                            out_free;

  bflm_pkg::cell_cmd_t             cmd;
  bflm_pkg::cell_bus_t             bus;
  bflm_pkg::chain_t                chain [bflm_pkg::POOL_FRAMES+1];
  bflm_pkg::cell_stat_t            stat  [bflm_pkg::POOL_FRAMES];

  logic [bflm_pkg::IDX_W-1:0]      sel_idx;
  logic [bflm_pkg::PAGE_W-1:0]     sel_page;
  logic [bflm_pkg::POOL_FRAMES-1:0] sel_vec;
  logic [bflm_pkg::POOL_FRAMES-1:0] valid_vec;

  logic [bflm_pkg::FRAME_W-1:0]    res_frame;
  logic                            res_hit;
  logic                            res_evict;
  logic [bflm_pkg::PAGE_W-1:0]     res_evict_page;
  logic                            res_read;
  logic                            res_zero;

  logic [bflm_pkg::FRAME_W-1:0]    out_frame;
  logic                            out_hit;
  logic                            out_evict;
  logic [bflm_pkg::PAGE_W-1:0]     out_evict_page;
  logic                            out_read;
  logic                            out_zero;

  assign full     = (unused_count == bflm_pkg::CNT_FULL);
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bflm_pkg::ST_IDLE:  if (s_tvalid) state_next = bflm_pkg::ST_MATCH;
      bflm_pkg::ST_MATCH: state_next = bflm_pkg::ST_PICK;
      bflm_pkg::ST_PICK:  state_next = bflm_pkg::ST_APPLY;
      bflm_pkg::ST_APPLY: state_next = bflm_pkg::ST_DONE;
      bflm_pkg::ST_DONE:  if (out_free) state_next = bflm_pkg::ST_IDLE;
      default:            state_next = bflm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready     = 1'b0;
    cmd.page     = page_q;
    cmd.fetch    = (act_q == bflm_pkg::ACT_FETCH);
    cmd.full     = full;
    cmd.found    = found_q;
    cmd.match_en = 1'b0;
    cmd.pick_en  = 1'b0;
    cmd.apply_en = 1'b0;
    unique case (state)
      bflm_pkg::ST_IDLE:  s_tready     = 1'b1;
      bflm_pkg::ST_MATCH: cmd.match_en = 1'b1;
      bflm_pkg::ST_PICK:  cmd.pick_en  = 1'b1;
      bflm_pkg::ST_APPLY: cmd.apply_en = 1'b1;
      bflm_pkg::ST_DONE:  ;
      default:            ;
    endcase
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < bflm_pkg::POOL_FRAMES; g++) begin : g_cell
    bflm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .bus       (bus),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .stat      (stat[g])
    );
    assign sel_vec[g]   = stat[g].sel;
    assign valid_vec[g] = stat[g].valid;
  end

  // gather the selected frame's state; exactly one cell is selected in apply
  always_comb begin
    bus.rank  = '0;
    bus.valid = 1'b0;
    sel_idx   = '0;
    sel_page  = '0;
    for (int i = 0; i < bflm_pkg::POOL_FRAMES; i++) begin
      if (stat[i].sel) begin
        bus.rank  = bus.rank | stat[i].rank;
        bus.valid = bus.valid | stat[i].valid;
        sel_idx   = sel_idx | bflm_pkg::IDX_W'(i);
        sel_page  = sel_page | stat[i].page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bflm_pkg::ST_IDLE;
      unused_count <= '0;
      found_q      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bflm_pkg::ST_PICK) begin
        found_q <= chain[bflm_pkg::POOL_FRAMES].hit;
      end
      if (state == bflm_pkg::ST_APPLY && !found_q && !full) begin
        unused_count <= unused_count + bflm_pkg::CNT_W'(1);
      end
      if (state == bflm_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act_q  <= s_tuser[0];
      page_q <= s_tdata[bflm_pkg::PAGE_W-1:0];
    end
    if (state == bflm_pkg::ST_APPLY) begin
      res_frame      <= bflm_pkg::FRAME_W'(sel_idx);
      res_hit        <= found_q;
      res_evict      <= !found_q && full;
      res_evict_page <= (!found_q && full) ? sel_page : '0;
      res_read       <= !found_q && (act_q == bflm_pkg::ACT_FETCH);
      res_zero       <= !found_q && (act_q == bflm_pkg::ACT_CREATE);
    end
    if (state == bflm_pkg::ST_DONE && out_free) begin
      out_frame      <= res_frame;
      out_hit        <= res_hit;
      out_evict      <= res_evict;
      out_evict_page <= res_evict_page;
      out_read       <= res_read;
      out_zero       <= res_zero;
    end
  end

  assign m_tdata = {1'b0, out_zero, out_read, out_evict_page, out_evict, out_hit, out_frame};

  // frames are taken from the unused pool in order and never released
  a_used_count : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(unused_count))
    else $error("valid frame count differs from used count");

  a_one_sel : assert property (@(posedge clk) disable iff (rst)
    state == bflm_pkg::ST_APPLY |-> $onehot(sel_vec))
    else $error("apply step without exactly one selected frame");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (state == bflm_pkg::ST_APPLY && !found_q && !full) |=>
      unused_count == $past(unused_count) + bflm_pkg::CNT_W'(1))
    else $error("used count did not advance on a fresh allocation");

  a_hit_found : assert property (@(posedge clk) disable iff (rst)
    (state == bflm_pkg::ST_APPLY && found_q) |-> bus.valid)
    else $error("hit selected a frame that is not valid");

endmodule

`default_nettype wire

// ===== sv/bflm_cell.sv =====
// One frame slot: page tag, valid bit, recency rank and priority chain stage.
`default_nettype none

module bflm_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bflm_pkg::cell_cmd_t cmd,
  input  wire bflm_pkg::cell_bus_t bus,
  input  wire bflm_pkg::chain_t    chain_in,
  output bflm_pkg::chain_t         chain_out,
  output bflm_pkg::cell_stat_t     stat
);

  logic                          valid;
  logic [bflm_pkg::RANK_W-1:0]   rank;
  logic [bflm_pkg::PAGE_W-1:0]   page;
  logic                          match_q;
  logic                          win_hit_q;
  logic                          win_alloc_q;
  logic                          alloc_cand;
  logic                          sel;

  // Miss: first never-used frame, or the oldest frame once all are used.
  assign alloc_cand = cmd.full ? (valid && rank == bflm_pkg::RANK_OLDEST) : !valid;

  assign chain_out.hit   = chain_in.hit   | match_q;
  assign chain_out.alloc = chain_in.alloc | alloc_cand;

  assign sel = cmd.found ? win_hit_q : win_alloc_q;

  assign stat.sel   = sel;
  assign stat.valid = valid;
  assign stat.rank  = rank;
  assign stat.page  = page;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      rank        <= '0;
      match_q     <= 1'b0;
      win_hit_q   <= 1'b0;
      win_alloc_q <= 1'b0;
    end else begin
      if (cmd.match_en) begin
        match_q <= valid && cmd.fetch && (page == cmd.page);
      end
      if (cmd.pick_en) begin
        win_hit_q   <= match_q & !chain_in.hit;
        win_alloc_q <= alloc_cand & !chain_in.alloc;
      end
      if (cmd.apply_en) begin
        if (sel) begin
          rank  <= '0;
          valid <= 1'b1;
        end else if (valid && (!bus.valid || rank < bus.rank)) begin
          // age valid frames more recent than the touched one (all valid frames if it was unused)
          rank <= rank + bflm_pkg::RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_en && sel) begin
      page <= cmd.page;
    end
  end

endmodule

`default_nettype wire

// ===== test/buffer_frame_lru_mapper_top_tb.sv =====
// Testbench for the buffer frame LRU mapper: directed and random page requests.
`timescale 1ns / 100ps

module buffer_frame_lru_mapper_top_tb;
  import bflm_pkg::*;

  localparam int RANDOM_PER_PHASE = 650;
  localparam int HOT_PAGES        = 20;
  localparam int QUIET_LIMIT      = 2000;
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    logic              act;
    logic [PAGE_W-1:0] page;
  } page_request_t;

  typedef struct packed {
    logic              need_zero;
    logic              need_read;
    logic [PAGE_W-1:0] evict_page;
    logic              evict_valid;
    logic              hit;
    logic [FRAME_W-1:0] frame;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  buffer_frame_lru_mapper_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Predictor copy of the frame table.
  logic [PAGE_W-1:0] held_page [POOL_FRAMES];
  logic              held_valid[POOL_FRAMES];
  logic [RANK_W-1:0] held_rank [POOL_FRAMES];
  int                frames_taken;

  page_request_t pending_requests[$];
  frame_result_t expected_frames[$];
  logic [PAGE_W-1:0] hot_pages[HOT_PAGES];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int request_count = 0;
  int result_count = 0;
  int hit_count = 0;
  int evict_count = 0;
  int create_count = 0;
  int quiet_cycles = 0;

  function automatic frame_result_t map_request(logic act, logic [PAGE_W-1:0] page);
    frame_result_t r;
    int f;
    int victim;
    bit found;
    bit was_valid;
    logic [RANK_W-1:0] old_rank;
    r = '0;
    f = 0;
    found = 0;
    if (act == ACT_FETCH) begin
      for (int i = 0; i < POOL_FRAMES; i++) begin
        if (!found && held_valid[i] && held_page[i] == page) begin
          f = i;
          found = 1;
        end
      end
    end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      if (frames_taken < POOL_FRAMES) begin
        f = frames_taken;
        frames_taken++;
      end else begin
        // Oldest valid frame goes; ties keep the lowest index.
        victim = -1;
        for (int i = 0; i < POOL_FRAMES; i++) begin
          if (held_valid[i] && (victim < 0 || held_rank[i] > held_rank[victim])) victim = i;
        end
        f = victim;
        r.evict_valid = 1'b1;
        r.evict_page = held_page[f];
      end
      held_page[f] = page;
      if (act == ACT_FETCH) r.need_read = 1'b1;
      else r.need_zero = 1'b1;
    end
    was_valid = held_valid[f];
    old_rank = held_rank[f];
    for (int i = 0; i < POOL_FRAMES; i++) begin
      if (i != f && held_valid[i] && (!was_valid || held_rank[i] < old_rank))
        held_rank[i] = held_rank[i] + 1'b1;
    end
    held_rank[f] = '0;
    held_valid[f] = 1'b1;
    r.frame = FRAME_W'(f);
    return r;
  endfunction

  task automatic queue_request(logic act, logic [PAGE_W-1:0] page);
    page_request_t req;
    req.act = act;
    req.page = page;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Hold off new requests until every result is back.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_tvalid || expected_frames.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    page_request_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req = pending_requests[0];
        pending_requests.delete(0);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, req.page};
        s_tuser <= req.act;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    bit bad;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        result_count++;
        got = m_tdata[OUT_W-2:0];
        if (expected_frames.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result transfer: %h", m_tdata);
        end else begin
          want = expected_frames[0];
          expected_frames.delete(0);
          bad = (got.frame !== want.frame) || (got.hit !== want.hit) ||
                (got.evict_valid !== want.evict_valid) ||
                (got.evict_page !== want.evict_page) ||
                (got.need_read !== want.need_read) || (got.need_zero !== want.need_zero) ||
                (m_tdata[OUT_W-1] !== 1'b0);
          if (bad) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("result %0d mismatch: exp frame=%0d hit=%b ev=%b ev_page=%h rd=%b zr=%b",
                       result_count, want.frame, want.hit, want.evict_valid,
                       want.evict_page, want.need_read, want.need_zero);
              $display("  got frame=%0d hit=%b ev=%b ev_page=%h rd=%b zr=%b pad=%b",
                       got.frame, got.hit, got.evict_valid, got.evict_page,
                       got.need_read, got.need_zero, m_tdata[OUT_W-1]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        request_count++;
        want = map_request(s_tuser[0], s_tdata[PAGE_W-1:0]);
        if (want.hit) hit_count++;
        if (want.evict_valid) evict_count++;
        if (s_tuser[0] == ACT_CREATE) create_count++;
        expected_frames.insert(expected_frames.size(), want);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    int slot;
    for (int i = 0; i < POOL_FRAMES; i++) begin
      held_page[i] = '0;
      held_valid[i] = 1'b0;
      held_rank[i] = '0;
    end
    frames_taken = 0;
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    for (int i = 2; i < HOT_PAGES; i++) hot_pages[i] = PAGE_W'($urandom());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme ids, hit, duplicate create, fill the pool, then evict.
    queue_request(ACT_FETCH, '0);
    queue_request(ACT_CREATE, '1);
    queue_request(ACT_FETCH, '0);
    queue_request(ACT_FETCH, '1);
    queue_request(ACT_CREATE, '1);
    queue_request(ACT_FETCH, '1);
    for (int i = 3; i < POOL_FRAMES; i++)
      queue_request(i[0] ? ACT_CREATE : ACT_FETCH, {i[3:0], 27'h5A5A5A5});
    queue_request(ACT_FETCH, 31'h0123_4567);
    queue_request(ACT_CREATE, 31'h2AAA_AAAA);
    queue_request(ACT_FETCH, '0);
    queue_request(ACT_FETCH, 31'h0123_4567);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
      receiver_stall_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = $urandom_range(99);
        slot = $urandom_range(HOT_PAGES - 1);
        if (r < 60) begin
          queue_request(ACT_FETCH, hot_pages[slot]);
        end else if (r < 75) begin
          // Fresh page joins the working set.
          hot_pages[slot] = PAGE_W'($urandom());
          queue_request(ACT_CREATE, hot_pages[slot]);
        end else if (r < 85) begin
          queue_request(ACT_CREATE, hot_pages[slot]);
        end else if (r < 95) begin
          queue_request(ACT_FETCH, PAGE_W'($urandom()));
        end else begin
          queue_request(1'($urandom_range(1)), $urandom_range(1) ? '1 : '0);
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $display("%0d results never arrived", expected_frames.size());
      error_count += expected_frames.size();
    end
    $display("run: %0d requests (%0d creates), %0d hits, %0d evictions",
             request_count, create_count, hit_count, evict_count);
    $display("run: %0d results checked over three idle/stall mixes, %0d errors",
             result_count, error_count);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
